// ----- rtl/core/josephus_permutation_generator_macros.svh -----
// ----------------------------------------------------------------------------
// Josephus permutation generator assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOSEPHUS_PERMUTATION_GENERATOR_MACROS_SVH
`define JOSEPHUS_PERMUTATION_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JPG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/jpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Josephus permutation generator package
// Field widths, the default circle size and the sequencer state type.
// ----------------------------------------------------------------------------
package jpg_pkg;

    localparam int POS_W     = 7;
    localparam int IN_W      = 7;
    localparam int MAX_N_DEF = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_MOVE,
        ST_EMIT
    } jpg_state_t;

endpackage

// ----- rtl/core/josephus_permutation_generator.sv -----
// ----------------------------------------------------------------------------
// Josephus permutation generator
// Fills a circular queue with positions 1 to n, then repeatedly rotates k-1
// entries from head to tail and removes the head, emitting it.
// ----------------------------------------------------------------------------
// A start word carries n_count and step_k and produces n result words, the
// last one flagged by last_out; an n_count of zero produces nothing, an
// n_count above MAX_N is taken as MAX_N and a step_k of zero acts as one.
// The queue lives in a single memory with one write and one read port, and
// every queue move passes through it: a run first fills the queue, then per
// result makes k-1 rotations and one removal and loads the result register,
// waiting while the output is stalled. The block takes a new start word only
// once the previous run has handed its last result to the output register.
`include "josephus_permutation_generator_macros.svh"

module josephus_permutation_generator #(
    parameter int MAX_N = jpg_pkg::MAX_N_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [jpg_pkg::IN_W-1:0]  n_count,
    input  logic [jpg_pkg::IN_W-1:0]  step_k,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [jpg_pkg::POS_W-1:0] position,
    output logic                      last_out
);

    import jpg_pkg::*;

    localparam int CNT_W = $clog2(MAX_N + 1);
    localparam int AW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam logic [CNT_W-1:0] MAX_N_C = CNT_W'(MAX_N);

    logic [POS_W-1:0] ring_mem [MAX_N];
    logic [POS_W-1:0] rd_data_reg;

    jpg_state_t       state_reg,    state_next;
    logic [CNT_W-1:0] cap_reg,      cap_next;
    logic [IN_W-1:0]  k_reg,        k_next;
    logic [AW-1:0]    head_reg,     head_next;
    logic [AW-1:0]    tail_reg,     tail_next;
    logic [CNT_W-1:0] cnt_reg,      cnt_next;
    logic [IN_W-1:0]  rot_cnt_reg,  rot_cnt_next;
    logic             wr_pend_reg,  wr_pend_next;
    logic             out_vld_reg,  out_vld_next;
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic             last_reg,     last_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [POS_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic             in_take;
    logic             load_out;
    logic             rotating;
    logic             run_done;
    logic [CNT_W-1:0] cnt_inc;
    logic [AW-1:0]    wrap_addr;
    logic [AW-1:0]    head_inc;
    logic [AW-1:0]    tail_inc;
    logic [CNT_W-1:0] n_eff;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_vld_reg;
    assign position  = pos_reg;
    assign last_out  = last_reg;

    assign cnt_inc   = cnt_reg + 1'b1;
    assign wrap_addr = AW'(cap_reg - 1'b1);
    assign head_inc  = (head_reg == wrap_addr) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == wrap_addr) ? '0 : tail_reg + 1'b1;
    assign rotating  = ({1'b0, rot_cnt_reg} + 8'd1) < {1'b0, k_reg};
    assign load_out  = (state_reg == ST_EMIT) && (!out_vld_reg || !out_stall);
    assign run_done  = (cnt_inc == cap_reg);
    assign n_eff     = (int'(n_count) > MAX_N) ? MAX_N_C : CNT_W'(n_count);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            if (mem_we && (mem_waddr == mem_raddr))
            begin
                rd_data_reg <= mem_wdata;
            end
            else
            begin
                rd_data_reg <= ring_mem[mem_raddr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cap_reg     <= '0;
            k_reg       <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            cnt_reg     <= '0;
            rot_cnt_reg <= '0;
            wr_pend_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            k_reg       <= k_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            rot_cnt_reg <= rot_cnt_next;
            wr_pend_reg <= wr_pend_next;
            out_vld_reg <= out_vld_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cap_next     = cap_reg;
        k_next       = k_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cnt_next     = cnt_reg;
        rot_cnt_next = rot_cnt_reg;
        wr_pend_next = 1'b0;
        pos_next     = pos_reg;
        last_next    = last_reg;
        out_vld_next = out_stall ? out_vld_reg : 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = tail_reg;
        mem_wdata    = rd_data_reg;
        mem_re       = 1'b0;
        mem_raddr    = head_reg;

        // A rotated word is written back to the tail in the cycle after its read.
        if (wr_pend_reg)
        begin
            mem_we    = 1'b1;
            tail_next = tail_inc;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (n_count != '0))
                begin
                    cap_next   = n_eff;
                    k_next     = (step_k == '0) ? IN_W'(1) : step_k;
                    head_next  = '0;
                    tail_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = POS_W'(cnt_inc);
                tail_next = tail_inc;
                if (run_done)
                begin
                    cnt_next     = '0;
                    rot_cnt_next = '0;
                    state_next   = ST_MOVE;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            ST_MOVE:
            begin
                mem_re    = 1'b1;
                head_next = head_inc;
                if (rotating)
                begin
                    rot_cnt_next = rot_cnt_reg + 1'b1;
                    wr_pend_next = 1'b1;
                end
                else
                begin
                    rot_cnt_next = '0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_vld_next = 1'b1;
                    pos_next     = rd_data_reg;
                    last_next    = run_done;
                    cnt_next     = cnt_inc;
                    state_next   = run_done ? ST_IDLE : ST_MOVE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `JPG_ASSERT_NEXT(a_start_fills, in_take && (n_count != '0), state_reg == ST_FILL,
        "Accepted start word did not begin the fill phase.")
    `JPG_ASSERT_NEXT(a_last_ends_run, load_out && run_done,
        state_reg == ST_IDLE && out_vld_reg && last_reg,
        "Final result did not end the run.")
    `JPG_ASSERT_SAME(a_ptr_in_ring, state_reg != ST_IDLE,
        {1'b0, head_reg} < {1'b0, cap_reg} && {1'b0, tail_reg} < {1'b0, cap_reg},
        "Queue pointer left the ring.")
    `JPG_ASSERT_SAME(a_pend_after_move, wr_pend_reg,
        state_reg == ST_MOVE || state_reg == ST_EMIT,
        "Pending rotation write outside the move phase.")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus permutation generator testbench
// Start words go in on the valid/stall input channel, and every elimination
// word that comes out is compared, field by field, with a local elimination
// predictor. A short table of directed start words comes first, then random
// start words under several patterns of sender gaps and receiver stalls,
// including a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

    import jpg_pkg::*;

    localparam int MAX_N       = MAX_N_DEF;
    localparam int LIMIT       = 10000000;
    localparam int HOLD_CYCLES = 1500;
    localparam int TAIL_CYCLES = 300;
    localparam int PHASE_ITEMS = 24;
    localparam int PRINT_MAX   = 50;

    typedef enum logic [1:0] {
        ANS_PREDICTED,
        ANS_ASCENDING,
        ANS_EMPTY
    } answer_t;

    typedef struct {
        logic [IN_W-1:0] n;
        logic [IN_W-1:0] k;
        answer_t         answer;
    } start_row_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             last;
    } elim_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [IN_W-1:0]   n_count   = '0;
    logic [IN_W-1:0]   step_k    = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [POS_W-1:0]  position;
    logic              last_out;

    elim_t             pending_elims[$];
    int                mismatches = 0;
    int                cycles     = 0;
    int                gap_pct    = 0;
    int                stall_pct  = 0;
    int                hold_tick  = 0;
    int                hold_seen  = 0;
    int                hold_left  = 0;

    start_row_t directed_starts [20] = '{
        '{7'd1,   7'd1,   ANS_ASCENDING},
        '{7'd0,   7'd5,   ANS_EMPTY},
        '{7'd0,   7'd0,   ANS_EMPTY},
        '{7'd1,   7'd127, ANS_ASCENDING},
        '{7'd5,   7'd0,   ANS_ASCENDING},
        '{7'd64,  7'd1,   ANS_ASCENDING},
        '{7'd127, 7'd1,   ANS_ASCENDING},
        '{7'd100, 7'd0,   ANS_ASCENDING},
        '{7'd2,   7'd2,   ANS_PREDICTED},
        '{7'd7,   7'd3,   ANS_PREDICTED},
        '{7'd41,  7'd3,   ANS_PREDICTED},
        '{7'd64,  7'd64,  ANS_PREDICTED},
        '{7'd3,   7'd127, ANS_PREDICTED},
        '{7'd10,  7'd100, ANS_PREDICTED},
        '{7'd65,  7'd2,   ANS_PREDICTED},
        '{7'd16,  7'd85,  ANS_PREDICTED},
        '{7'd42,  7'd42,  ANS_PREDICTED},
        '{7'd0,   7'd127, ANS_EMPTY},
        '{7'd127, 7'd127, ANS_PREDICTED},
        '{7'd1,   7'd0,   ANS_ASCENDING}
    };

    josephus_permutation_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .n_count   (n_count),
        .step_k    (step_k),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position),
        .last_out  (last_out)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic flag_word(input string what, input int got, input int want);
        if (mismatches < PRINT_MAX)
        begin
            $display("%0t: %s: got %0d, wanted %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Works through the elimination order of one run and queues every word.
    task automatic queue_eliminations(input logic [IN_W-1:0] n_in,
                                      input logic [IN_W-1:0] k_in);
        logic [POS_W-1:0] ring [MAX_N];
        logic [POS_W-1:0] moved;
        int               cap;
        int               head;
        int               fill;
        int               out_no;
        int               r;
        int               i;
        elim_t            word;

        if (n_in == '0)
        begin
            return;
        end
        cap  = (n_in > MAX_N) ? MAX_N : int'(n_in);
        head = 0;
        fill = cap;
        for (i = 0; i < cap; i++)
        begin
            ring[i] = POS_W'(i + 1);
        end
        for (out_no = 1; out_no <= cap; out_no++)
        begin
            for (r = 1; r < int'(k_in); r++)
            begin
                moved = ring[head];
                head  = (head + 1) % cap;
                ring[(head + fill - 1) % cap] = moved;
            end
            word.position = ring[head];
            word.last     = (out_no == cap);
            pending_elims.push_back(word);
            head = (head + 1) % cap;
            fill--;
        end
    endtask

    task automatic offer_start(input logic [IN_W-1:0] n, input logic [IN_W-1:0] k,
                               input answer_t answer);
        int    sat_n;
        int    i;
        elim_t word;

        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        n_count  <= n;
        step_k   <= k;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        case (answer)
            ANS_EMPTY:
            begin
            end
            ANS_ASCENDING:
            begin
                sat_n = (n > MAX_N) ? MAX_N : int'(n);
                for (i = 1; i <= sat_n; i++)
                begin
                    word.position = POS_W'(i);
                    word.last     = (i == sat_n);
                    pending_elims.push_back(word);
                end
            end
            default:
            begin
                queue_eliminations(n, k);
            end
        endcase
    endtask

    task automatic offer_random_start();
        int              sel;
        logic [IN_W-1:0] n;
        logic [IN_W-1:0] k;

        sel = $urandom_range(99);
        if (sel < 8)
        begin
            n = '0;
            k = IN_W'($urandom_range(127));
        end
        else if (sel < 14)
        begin
            n = IN_W'($urandom_range(127, 65));
            k = IN_W'($urandom_range(127));
        end
        else if (sel < 20)
        begin
            n = IN_W'($urandom_range(64, 33));
            k = IN_W'($urandom_range(64));
        end
        else if (sel < 30)
        begin
            n = IN_W'($urandom_range(8, 1));
            k = IN_W'($urandom_range(127, 9));
        end
        else
        begin
            n = IN_W'($urandom_range(16, 1));
            k = IN_W'($urandom_range(12));
        end
        offer_start(n, k, ANS_PREDICTED);
    endtask

    task automatic wait_drained();
        while (pending_elims.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_elims.size() == 0)
            begin
                flag_word("unexpected word, position", int'(position), 0);
            end
            else
            begin
                if (position !== pending_elims[0].position)
                begin
                    flag_word("position", int'(position), int'(pending_elims[0].position));
                end
                if (last_out !== pending_elims[0].last)
                begin
                    flag_word("last_out", int'(last_out), int'(pending_elims[0].last));
                end
                void'(pending_elims.pop_front());
            end
        end
        if (hold_tick != hold_seen)
        begin
            hold_seen <= hold_tick;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        int row;
        int ph;
        int i;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < $size(directed_starts); row++)
        begin
            offer_start(directed_starts[row].n, directed_starts[row].k,
                        directed_starts[row].answer);
        end
        in_valid <= 1'b0;
        wait_drained();

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin gap_pct <= 0;  stall_pct <= 0;  end
                1: begin gap_pct <= 82; stall_pct <= 0;  end
                2: begin gap_pct <= 0;  stall_pct <= 82; end
                3: begin gap_pct <= 22; stall_pct <= 22; end
                default:
                begin
                    gap_pct   <= 0;
                    stall_pct <= 0;
                    hold_tick <= hold_tick + 1;
                end
            endcase
            @(posedge clk);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                offer_random_start();
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_elims.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
